### rtl/core/lvps_pkg.sv
// Shared constants for the longest valid parenthesis span unit.
`default_nettype none

package lvps_pkg;

  // Default for the longest string that is fully evaluated.
  localparam int unsigned MaxLenDefault = 1024;

  // Width of one input symbol and the byte that opens a span.
  localparam int unsigned SymW     = 8;
  localparam logic [SymW-1:0] OpenByte = 8'd40;

  // Width of the reported span and of the padded result bus.
  localparam int unsigned SpanOutW = 11;
  localparam int unsigned OutDataW = 16;

endpackage : lvps_pkg

`default_nettype wire

### rtl/core/longest_valid_paren_span_unit.sv
// Longest well-formed parenthesis span over a byte stream, one result per string.
`default_nettype none

// The unit takes a string one byte per beat (tlast marks its final byte) and,
// for each string, returns one beat with the length of the longest well-formed
// parenthesized substring in tdata[10:0] and an overflow flag in tuser. Byte 40
// opens a span; every other byte closes one. Positions of open bytes live in a
// stack memory and the span ending at each position lives in a span memory,
// both synchronous RAMs. Each byte passes three stages: stack access, span
// lookup, span write-back. A new byte is taken only while the span lookup stage
// is empty, since a closing byte reads the stack top and then the span memory
// at the address that read returned. A result beat that is not taken stalls the
// pipeline only when the next finished byte is itself a last byte. Strings
// longer than MAX_LEN bytes set the overflow flag; the span then covers the
// first MAX_LEN bytes only. No clearing pass is needed after reset.
module longest_valid_paren_span_unit
  import lvps_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input byte stream.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [SymW-1:0]     s_axis_tdata_i,   // [7:0] symbol
  input  wire logic                s_axis_tlast_i,   // last_symbol
  // Result stream.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,   // [10:0] longest_span, rest zero
  output logic                     m_axis_tuser_o    // [0] length_overflow
);

  // Address width of both memories and width of positions and spans.
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] MaxPos = PW'(MAX_LEN);

  // Storage.
  logic [AW-1:0] stk_mem [MAX_LEN];
  logic [PW-1:0] spn_mem [MAX_LEN];

  // String-level state.
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [PW-1:0] best_q, best_d;

  // Stage B: stack top available.
  logic          b_vld_q;
  logic [AW-1:0] b_pos_q;
  logic          b_pop_q, b_proc_q, b_last_q, b_ovf_q;
  logic [AW-1:0] stk_rd_q;

  // Stage C: stored span available.
  logic          c_vld_q;
  logic [AW-1:0] c_pos_q;
  logic [PW-1:0] c_base_q;
  logic          c_prev_q, c_proc_q, c_last_q, c_ovf_q;
  logic [PW-1:0] spn_rd_q;

  // Result register.
  logic                out_vld_q;
  logic [SpanOutW-1:0] out_span_q;
  logic                out_ovf_q;

  logic          acc;
  logic          is_open, proc, push, pop;
  logic          b_go, c_go;
  logic          b_prev;
  logic [PW-1:0] b_base;
  logic [PW-1:0] c_len;

  // Stage A decode: the stack decision needs only the byte, the position and the count.
  assign s_axis_tready_o = !b_vld_q;
  assign acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign is_open = (s_axis_tdata_i == OpenByte);
  assign proc    = (pos_q != MaxPos);
  assign push    = proc && is_open;
  assign pop     = proc && !is_open && (cnt_q != '0);

  // Pipeline advance conditions.
  assign c_go = c_vld_q && (!c_last_q || !out_vld_q || m_axis_tready_i);
  assign b_go = b_vld_q && (!c_vld_q || c_go);

  // Stage B: span base and whether a preceding stored span is added.
  assign b_prev = b_pop_q && (stk_rd_q != '0);
  assign b_base = b_pop_q ? (PW'(b_pos_q) - PW'(stk_rd_q) + PW'(1)) : '0;

  // Stage C: full span ending at this position.
  assign c_len = c_base_q + (c_prev_q ? spn_rd_q : '0);

  // Next values of the string-level state.
  always_comb begin
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    best_d = best_q;
    if (acc) begin
      if (proc) begin
        pos_d = pos_q + PW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (push) begin
        cnt_d = cnt_q + PW'(1);
      end else if (pop) begin
        cnt_d = cnt_q - PW'(1);
      end
      if (s_axis_tlast_i) begin
        pos_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end
    end
    if (c_go) begin
      if (c_proc_q && (c_len > best_q)) begin
        best_d = c_len;
      end
      if (c_last_q) begin
        best_d = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      best_q    <= '0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      best_q <= best_d;
      if (acc) begin
        b_vld_q <= 1'b1;
      end else if (b_go) begin
        b_vld_q <= 1'b0;
      end
      if (b_go) begin
        c_vld_q <= 1'b1;
      end else if (c_go) begin
        c_vld_q <= 1'b0;
      end
      if (c_go && c_last_q) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers of the pipeline and the result.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_pos_q  <= pos_q[AW-1:0];
      b_pop_q  <= pop;
      b_proc_q <= proc;
      b_last_q <= s_axis_tlast_i;
      b_ovf_q  <= ovf_q || !proc;
    end
    if (b_go) begin
      c_pos_q  <= b_pos_q;
      c_base_q <= b_base;
      c_prev_q <= b_prev;
      c_proc_q <= b_proc_q;
      c_last_q <= b_last_q;
      c_ovf_q  <= b_ovf_q;
    end
    if (c_go && c_last_q) begin
      out_span_q <= SpanOutW'((c_proc_q && (c_len > best_q)) ? c_len : best_q);
      out_ovf_q  <= c_ovf_q;
    end
  end

  // Stack memory: push writes the top slot, pop reads the slot below the count.
  always_ff @(posedge clk_i) begin
    if (acc && push) begin
      stk_mem[cnt_q[AW-1:0]] <= pos_q[AW-1:0];
    end
    if (acc && pop) begin
      stk_rd_q <= stk_mem[cnt_q[AW-1:0] - AW'(1)];
    end
  end

  // Span memory: lookup at the position before the matched open byte, and
  // write-back of the span at the current position. A lookup never targets
  // the position being written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (b_go && b_prev) begin
      spn_rd_q <= spn_mem[stk_rd_q - AW'(1)];
    end
    if (c_go && c_proc_q) begin
      spn_mem[c_pos_q] <= c_len;
    end
  end

  // Result beat.
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - SpanOutW){1'b0}}, out_span_q};
  assign m_axis_tuser_o  = out_ovf_q;

endmodule : longest_valid_paren_span_unit

`default_nettype wire
